[rtl/core/ppb_pkg.sv]
// shared constants, register codes and the cordic angle table for the pose blend
`default_nettype none

package ppb_pkg;

   localparam int XY_WIDTH       = 64;
   localparam int Z_WIDTH        = 32;
   localparam int YAW_WIDTH      = 16;
   localparam int FLAG_WIDTH     = 4;
   localparam int WEIGHT_WIDTH   = 17;
   localparam int REG_INDEX_WIDTH = 1;

   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE = 17'd65536;
   localparam int MIN_IMU_DIST_SQ = 4295;
   localparam int DIST_MARGIN     = 9830;

   localparam int FLAG_PREV_EXT = 0;
   localparam int FLAG_PREV_MAP = 1;
   localparam int FLAG_CUR_EXT  = 2;
   localparam int FLAG_IMU      = 3;

   localparam int CORDIC_STEPS   = 30;
   localparam int CORDIC_WIDTH   = 34;
   localparam int SINCOS_WIDTH   = 32;
   localparam int CORDIC_LATENCY = CORDIC_STEPS + 2;
   localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef enum logic [REG_INDEX_WIDTH-1:0] {
      REG_YAW_WEIGHT      = 1'b0,
      REG_POSITION_WEIGHT = 1'b1
   } reg_index_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic signed [CORDIC_WIDTH-1:0] atan_turn(input int idx);
      logic signed [CORDIC_WIDTH-1:0] v;
      unique case (idx)
         0:  v = 34'sd536870912;
         1:  v = 34'sd316933406;
         2:  v = 34'sd167458907;
         3:  v = 34'sd85004756;
         4:  v = 34'sd42667331;
         5:  v = 34'sd21354465;
         6:  v = 34'sd10679838;
         7:  v = 34'sd5340245;
         8:  v = 34'sd2670163;
         9:  v = 34'sd1335087;
         10: v = 34'sd667544;
         11: v = 34'sd333772;
         12: v = 34'sd166886;
         13: v = 34'sd83443;
         14: v = 34'sd41722;
         15: v = 34'sd20861;
         16: v = 34'sd10430;
         17: v = 34'sd5215;
         18: v = 34'sd2608;
         19: v = 34'sd1304;
         20: v = 34'sd652;
         21: v = 34'sd326;
         22: v = 34'sd163;
         23: v = 34'sd81;
         24: v = 34'sd41;
         25: v = 34'sd20;
         26: v = 34'sd10;
         27: v = 34'sd5;
         28: v = 34'sd3;
         29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[rtl/core/ppb_if.sv]
// request and response channel interfaces of the pose blend
`default_nettype none

interface ppb_req_if import ppb_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [XY_WIDTH-1:0]          prev_ext_xy;
   logic signed [Z_WIDTH-1:0]    prev_ext_z;
   logic signed [YAW_WIDTH-1:0]  prev_ext_yaw;
   logic [XY_WIDTH-1:0]          prev_map_xy;
   logic signed [Z_WIDTH-1:0]    prev_map_z;
   logic signed [YAW_WIDTH-1:0]  prev_map_yaw;
   logic [XY_WIDTH-1:0]          cur_ext_xy;
   logic signed [Z_WIDTH-1:0]    cur_ext_z;
   logic signed [YAW_WIDTH-1:0]  cur_ext_yaw;
   logic [XY_WIDTH-1:0]          imu_delta_xy;
   logic signed [YAW_WIDTH-1:0]  imu_delta_yaw;
   logic [FLAG_WIDTH-1:0]        valid_flags;

   modport source (output valid, prev_ext_xy, prev_ext_z, prev_ext_yaw, prev_map_xy,
                   prev_map_z, prev_map_yaw, cur_ext_xy, cur_ext_z, cur_ext_yaw,
                   imu_delta_xy, imu_delta_yaw, valid_flags, input ready);
   modport sink   (input valid, prev_ext_xy, prev_ext_z, prev_ext_yaw, prev_map_xy,
                   prev_map_z, prev_map_yaw, cur_ext_xy, cur_ext_z, cur_ext_yaw,
                   imu_delta_xy, imu_delta_yaw, valid_flags, output ready);
endinterface

interface ppb_rsp_if import ppb_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [Z_WIDTH-1:0]    pred_x;
   logic signed [Z_WIDTH-1:0]    pred_y;
   logic signed [Z_WIDTH-1:0]    pred_z;
   logic signed [YAW_WIDTH-1:0]  pred_yaw;
   logic                         pred_valid;
   logic                         used_imu;

   modport source (output valid, pred_x, pred_y, pred_z, pred_yaw, pred_valid, used_imu,
                   input ready);
   modport sink   (input valid, pred_x, pred_y, pred_z, pred_yaw, pred_valid, used_imu,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/planar_pose_prediction_blend.sv]
// top level: relative planar motion, imu blend and composition onto the mapping pose
// the 32-stage cordic and the one-bit-per-stage square root lie in series in the pipe
// throughput: one item per cycle; the whole pipe halts while a result waits
// reset clears every valid bit and both blend weights; no clearing pass
`default_nettype none

module planar_pose_prediction_blend import ppb_pkg::*; #(
   parameter int POSITION_WIDTH = 32,
   parameter int ANGLE_WIDTH    = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   ppb_req_if.sink                     req_ch,
   ppb_rsp_if.source                   rsp_ch,
   input  logic                        csr_we,
   input  logic [REG_INDEX_WIDTH-1:0]  csr_index,
   input  logic [WEIGHT_WIDTH-1:0]     csr_wdata
);

   localparam int PW   = POSITION_WIDTH;
   localparam int AW   = ANGLE_WIDTH;
   localparam int WIDE = PW + 40;
   localparam int SQW  = 2*PW;
   localparam int PRW  = PW + 1 + SINCOS_WIDTH;
   localparam int BPW  = PW + 18;
   localparam int YPW  = AW + 18;
   localparam int FPW  = PW + SINCOS_WIDTH;

   localparam logic signed [WIDE-1:0] POS_MAX = WIDE'((64'sd1 <<< (PW-1)) - 64'sd1);
   localparam logic signed [WIDE-1:0] POS_MIN = -POS_MAX - WIDE'(1);

   typedef struct packed {
      logic                      valid;
      logic [FLAG_WIDTH-1:0]     flags;
      logic                      all_valid;
      logic                      used;
      logic signed [PW-1:0]      cx, cy, cz;
      logic signed [AW-1:0]      cyaw;
      logic signed [PW-1:0]      mx, my, mz;
      logic signed [AW-1:0]      myaw, pyaw;
      logic signed [PW-1:0]      ix, iy;
      logic signed [AW-1:0]      iyaw;
      logic signed [PW:0]        dx, dy;
      logic signed [PW-1:0]      rz;
      logic signed [AW-1:0]      ryaw;
      logic [SQW-1:0]            ixx, iyy, isq;
      logic signed [SINCOS_WIDTH-1:0] mc, ms;
      logic signed [PRW-1:0]     p0, p1, p2, p3;
      logic signed [PW-1:0]      rx, ry;
      logic [SQW-1:0]            rxx, ryy;
      logic [PW-1:0]             de, di;
      logic [WEIGHT_WIDTH-1:0]   wp;
      logic signed [BPW-1:0]     b0, b1, b2, b3;
      logic signed [YPW-1:0]     b4, b5;
      logic signed [FPW-1:0]     q0, q1, q2, q3;
      logic signed [PW-1:0]      ox, oy, oz;
      logic signed [AW-1:0]      oyaw;
      logic                      ovalid;
   } ctx_type;

   function automatic logic signed [PW-1:0] sat_pos(input logic signed [WIDE-1:0] v);
      logic signed [WIDE-1:0] r;
      if (v < POS_MIN)      r = POS_MIN;
      else if (v > POS_MAX) r = POS_MAX;
      else                  r = v;
      return r[PW-1:0];
   endfunction

   // round half up at bit 30, floor shift
   function automatic logic signed [WIDE-1:0] rnd30(input logic signed [WIDE-1:0] v);
      logic signed [WIDE-1:0] t;
      t = v + WIDE'(64'sd536870912);
      return t >>> 30;
   endfunction

   // configuration
   logic [WEIGHT_WIDTH-1:0] yaw_wt_ff, pos_weight_ff;
   logic [WEIGHT_WIDTH-1:0] yaw_wt, pos_weight;

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_wt_ff     <= '0;
         pos_weight_ff <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_YAW_WEIGHT:      yaw_wt_ff     <= csr_wdata;
            REG_POSITION_WEIGHT: pos_weight_ff <= csr_wdata;
         endcase
      end
   end

   assign yaw_wt     = (yaw_wt_ff > WEIGHT_ONE) ? WEIGHT_ONE : yaw_wt_ff;
   assign pos_weight = (pos_weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : pos_weight_ff;

   logic advance;

   ctx_type a_in, a_ff, b_in, b_ff, d_in, d_ff, e_in, e_ff;
   ctx_type f_in, f_ff, g_in, g_ff, h_in, h_ff, i_in, i_ff, o_in, o_ff;
   ctx_type cd_ff [CORDIC_LATENCY];
   ctx_type sq_ff [PW];

   logic signed [SINCOS_WIDTH-1:0] pc, ps, mc, ms;
   logic [PW-1:0] de, di;

   assign advance      = !o_ff.valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   // input decode, differences and imu squares
   always_comb begin
      logic signed [PW-1:0] px, py, pz, cx, cy, cz, ix, iy;
      logic signed [AW-1:0] pyaw, cyaw;
      logic signed [SQW-1:0] sx, sy;
      logic signed [PW:0] dz;
      px   = req_ch.prev_ext_xy[PW-1:0];
      py   = req_ch.prev_ext_xy[32+PW-1:32];
      pz   = req_ch.prev_ext_z[PW-1:0];
      pyaw = AW'(req_ch.prev_ext_yaw);
      cx   = req_ch.cur_ext_xy[PW-1:0];
      cy   = req_ch.cur_ext_xy[32+PW-1:32];
      cz   = req_ch.cur_ext_z[PW-1:0];
      cyaw = AW'(req_ch.cur_ext_yaw);
      ix   = req_ch.imu_delta_xy[PW-1:0];
      iy   = req_ch.imu_delta_xy[32+PW-1:32];
      sx   = ix * ix;
      sy   = iy * iy;
      dz   = (PW+1)'(cz) - (PW+1)'(pz);

      a_in           = a_ff;
      a_in.valid     = req_ch.valid;
      a_in.flags     = req_ch.valid_flags;
      a_in.all_valid = req_ch.valid_flags[FLAG_PREV_EXT] && req_ch.valid_flags[FLAG_PREV_MAP]
                       && req_ch.valid_flags[FLAG_CUR_EXT];
      a_in.used      = a_in.all_valid && req_ch.valid_flags[FLAG_IMU];
      a_in.cx        = cx;
      a_in.cy        = cy;
      a_in.cz        = cz;
      a_in.cyaw      = cyaw;
      a_in.mx        = req_ch.prev_map_xy[PW-1:0];
      a_in.my        = req_ch.prev_map_xy[32+PW-1:32];
      a_in.mz        = req_ch.prev_map_z[PW-1:0];
      a_in.myaw      = AW'(req_ch.prev_map_yaw);
      a_in.pyaw      = pyaw;
      a_in.ix        = ix;
      a_in.iy        = iy;
      a_in.iyaw      = AW'(req_ch.imu_delta_yaw);
      a_in.dx        = (PW+1)'(cx) - (PW+1)'(px);
      a_in.dy        = (PW+1)'(cy) - (PW+1)'(py);
      a_in.rz        = sat_pos(WIDE'(dz));
      a_in.ryaw      = cyaw - pyaw;
      a_in.ixx       = $unsigned(sx);
      a_in.iyy       = $unsigned(sy);
   end

   always_ff @(posedge clock) begin
      if (reset) a_ff.valid <= 1'b0;
      else if (advance) a_ff <= a_in;
   end

   ppb_cordic #(.ANGLE_WIDTH(AW)) u_cordic_prev (
      .clock(clock), .en(advance), .angle(a_ff.pyaw), .cos_out(pc), .sin_out(ps)
   );

   ppb_cordic #(.ANGLE_WIDTH(AW)) u_cordic_map (
      .clock(clock), .en(advance), .angle(a_ff.myaw), .cos_out(mc), .sin_out(ms)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CORDIC_LATENCY; k++) cd_ff[k].valid <= 1'b0;
      end else if (advance) begin
         cd_ff[0] <= a_ff;
         for (int k = 1; k < CORDIC_LATENCY; k++) cd_ff[k] <= cd_ff[k-1];
      end
   end

   // rotate the external motion into the previous external frame
   always_comb begin
      logic signed [PW:0] dx, dy;
      dx = cd_ff[CORDIC_LATENCY-1].dx;
      dy = cd_ff[CORDIC_LATENCY-1].dy;
      b_in     = cd_ff[CORDIC_LATENCY-1];
      b_in.mc  = mc;
      b_in.ms  = ms;
      b_in.p0  = pc * dx;
      b_in.p1  = ps * dy;
      b_in.p2  = pc * dy;
      b_in.p3  = ps * dx;
      b_in.isq = b_in.ixx + b_in.iyy;
   end

   always_ff @(posedge clock) begin
      if (reset) b_ff.valid <= 1'b0;
      else if (advance) b_ff <= b_in;
   end

   always_comb begin
      logic signed [PRW-1:0] p0, p1, p2, p3;
      p0 = b_ff.p0;
      p1 = b_ff.p1;
      p2 = b_ff.p2;
      p3 = b_ff.p3;
      d_in    = b_ff;
      d_in.rx = sat_pos(rnd30(WIDE'(p0) + WIDE'(p1)));
      d_in.ry = sat_pos(rnd30(WIDE'(p2) - WIDE'(p3)));
   end

   always_ff @(posedge clock) begin
      if (reset) d_ff.valid <= 1'b0;
      else if (advance) d_ff <= d_in;
   end

   always_comb begin
      logic signed [PW-1:0] rx, ry;
      logic signed [SQW-1:0] sx, sy;
      rx = d_ff.rx;
      ry = d_ff.ry;
      sx = rx * rx;
      sy = ry * ry;
      e_in     = d_ff;
      e_in.rxx = $unsigned(sx);
      e_in.ryy = $unsigned(sy);
   end

   always_ff @(posedge clock) begin
      if (reset) e_ff.valid <= 1'b0;
      else if (advance) e_ff <= e_in;
   end

   ppb_isqrt #(.POSITION_WIDTH(PW)) u_isqrt_ext (
      .clock(clock), .en(advance), .radicand(e_ff.rxx + e_ff.ryy), .root(de)
   );

   ppb_isqrt #(.POSITION_WIDTH(PW)) u_isqrt_imu (
      .clock(clock), .en(advance), .radicand(e_ff.isq), .root(di)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PW; k++) sq_ff[k].valid <= 1'b0;
      end else if (advance) begin
         sq_ff[0] <= e_ff;
         for (int k = 1; k < PW; k++) sq_ff[k] <= sq_ff[k-1];
      end
   end

   // distance gate on the position weight
   always_comb begin
      logic [PW-1:0] diff;
      logic [PW:0]   limit;
      logic          reject;
      diff   = (di > de) ? (di - de) : (de - di);
      limit  = (PW+1)'(de) + (PW+1)'(DIST_MARGIN);
      reject = (sq_ff[PW-1].isq < SQW'(MIN_IMU_DIST_SQ)) || ((PW+1)'(diff) > limit);
      f_in    = sq_ff[PW-1];
      f_in.de = de;
      f_in.di = di;
      f_in.wp = reject ? '0 : pos_weight;
   end

   always_ff @(posedge clock) begin
      if (reset) f_ff.valid <= 1'b0;
      else if (advance) f_ff <= f_in;
   end

   always_comb begin
      logic signed [WEIGHT_WIDTH:0] wp, wpc, wy, wyc;
      logic signed [PW-1:0] rx, ry, ix, iy;
      logic signed [AW-1:0] ryaw, iyaw;
      wp   = {1'b0, f_ff.wp};
      wpc  = {1'b0, WEIGHT_ONE - f_ff.wp};
      wy   = {1'b0, yaw_wt};
      wyc  = {1'b0, WEIGHT_ONE - yaw_wt};
      rx   = f_ff.rx;
      ry   = f_ff.ry;
      ix   = f_ff.ix;
      iy   = f_ff.iy;
      ryaw = f_ff.ryaw;
      iyaw = f_ff.iyaw;
      g_in    = f_ff;
      g_in.b0 = wpc * rx;
      g_in.b1 = wp * ix;
      g_in.b2 = wpc * ry;
      g_in.b3 = wp * iy;
      g_in.b4 = wyc * ryaw;
      g_in.b5 = wy * iyaw;
   end

   always_ff @(posedge clock) begin
      if (reset) g_ff.valid <= 1'b0;
      else if (advance) g_ff <= g_in;
   end

   always_comb begin
      logic signed [BPW-1:0] b0, b1, b2, b3;
      logic signed [YPW-1:0] b4, b5;
      logic signed [WIDE-1:0] sx, sy;
      logic signed [YPW:0]    syaw;
      b0   = g_ff.b0;
      b1   = g_ff.b1;
      b2   = g_ff.b2;
      b3   = g_ff.b3;
      b4   = g_ff.b4;
      b5   = g_ff.b5;
      sx   = WIDE'(b0) + WIDE'(b1) + WIDE'(32'sd32768);
      sy   = WIDE'(b2) + WIDE'(b3) + WIDE'(32'sd32768);
      syaw = (YPW+1)'(b4) + (YPW+1)'(b5) + (YPW+1)'(32'sd32768);
      h_in = g_ff;
      if (g_ff.used) begin
         h_in.rx   = sat_pos(sx >>> 16);
         h_in.ry   = sat_pos(sy >>> 16);
         h_in.ryaw = AW'(syaw >>> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) h_ff.valid <= 1'b0;
      else if (advance) h_ff <= h_in;
   end

   // rotate the blended motion into the mapping frame
   always_comb begin
      logic signed [SINCOS_WIDTH-1:0] c, s;
      logic signed [PW-1:0] rx, ry;
      c  = h_ff.mc;
      s  = h_ff.ms;
      rx = h_ff.rx;
      ry = h_ff.ry;
      i_in    = h_ff;
      i_in.q0 = c * rx;
      i_in.q1 = s * ry;
      i_in.q2 = s * rx;
      i_in.q3 = c * ry;
   end

   always_ff @(posedge clock) begin
      if (reset) i_ff.valid <= 1'b0;
      else if (advance) i_ff <= i_in;
   end

   always_comb begin
      logic signed [FPW-1:0] q0, q1, q2, q3;
      logic signed [PW-1:0]  mx, my, mz, rz;
      q0 = i_ff.q0;
      q1 = i_ff.q1;
      q2 = i_ff.q2;
      q3 = i_ff.q3;
      mx = i_ff.mx;
      my = i_ff.my;
      mz = i_ff.mz;
      rz = i_ff.rz;
      o_in = i_ff;
      if (i_ff.all_valid) begin
         o_in.ox     = sat_pos(WIDE'(mx) + rnd30(WIDE'(q0) - WIDE'(q1)));
         o_in.oy     = sat_pos(WIDE'(my) + rnd30(WIDE'(q2) + WIDE'(q3)));
         o_in.oz     = sat_pos(WIDE'(mz) + WIDE'(rz));
         o_in.oyaw   = i_ff.myaw + i_ff.ryaw;
         o_in.ovalid = 1'b1;
      end else begin
         // some pose missing: current external pose goes straight out
         o_in.ox     = i_ff.cx;
         o_in.oy     = i_ff.cy;
         o_in.oz     = i_ff.cz;
         o_in.oyaw   = i_ff.cyaw;
         o_in.ovalid = i_ff.flags[FLAG_CUR_EXT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) o_ff.valid <= 1'b0;
      else if (advance) o_ff <= o_in;
   end

   assign rsp_ch.valid      = o_ff.valid;
   assign rsp_ch.pred_x     = Z_WIDTH'(o_ff.ox);
   assign rsp_ch.pred_y     = Z_WIDTH'(o_ff.oy);
   assign rsp_ch.pred_z     = Z_WIDTH'(o_ff.oz);
   assign rsp_ch.pred_yaw   = YAW_WIDTH'(o_ff.oyaw);
   assign rsp_ch.pred_valid = o_ff.ovalid;
   assign rsp_ch.used_imu   = o_ff.used;

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_stall_holds_entry: assert property (@(posedge clock) disable iff (reset)
      !advance && a_ff.valid |=> a_ff.valid)
      else $error("entry stage item lost during stall");

   a_gate_weight_range: assert property (@(posedge clock) disable iff (reset)
      f_ff.valid |-> f_ff.wp <= WEIGHT_ONE)
      else $error("position weight above one");

   a_imu_implies_valid: assert property (@(posedge clock) disable iff (reset)
      o_ff.valid && o_ff.used |-> o_ff.ovalid && o_ff.all_valid)
      else $error("imu blend reported on an invalid pose");

endmodule

`default_nettype wire

[rtl/core/ppb_cordic.sv]
// pipelined rotation cordic giving cos and sin of a binary angle in q2.30
`default_nettype none

module ppb_cordic import ppb_pkg::*; #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [ANGLE_WIDTH-1:0]   angle,
   output logic signed [SINCOS_WIDTH-1:0]  cos_out,
   output logic signed [SINCOS_WIDTH-1:0]  sin_out
);

   logic signed [CORDIC_WIDTH-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_WIDTH-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [CORDIC_WIDTH-1:0] z_ff [CORDIC_STEPS+1];
   logic                           flip_ff [CORDIC_STEPS+1];
   logic signed [SINCOS_WIDTH-1:0] cos_ff, sin_ff;

   logic [31:0] a_turn, a_rot;
   logic        flip_in;

   // second and third quadrants are rotated by half a turn and negated at the end
   always_comb begin
      a_turn  = {angle, {(32-ANGLE_WIDTH){1'b0}}};
      flip_in = a_turn[31] ^ a_turn[30];
      a_rot   = {a_turn[31] ^ flip_in, a_turn[30:0]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= CORDIC_WIDTH'($signed(a_rot));
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic signed [CORDIC_WIDTH-1:0] ATAN = atan_turn(i);
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][CORDIC_WIDTH-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (flip_ff[CORDIC_STEPS]) begin
            cos_ff <= SINCOS_WIDTH'(-x_ff[CORDIC_STEPS]);
            sin_ff <= SINCOS_WIDTH'(-y_ff[CORDIC_STEPS]);
         end else begin
            cos_ff <= SINCOS_WIDTH'(x_ff[CORDIC_STEPS]);
            sin_ff <= SINCOS_WIDTH'(y_ff[CORDIC_STEPS]);
         end
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

`default_nettype wire

[rtl/core/ppb_isqrt.sv]
// pipelined integer square root, one result bit per stage
`default_nettype none

module ppb_isqrt #(
   parameter int POSITION_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [2*POSITION_WIDTH-1:0]   radicand,
   output logic [POSITION_WIDTH-1:0]     root
);

   localparam int PW = POSITION_WIDTH;
   localparam int NW = 2*PW + 1;

   logic [NW-1:0] n_ff [PW];
   logic [NW-1:0] r_ff [PW];

   for (genvar j = 0; j < PW; j++) begin : g_step
      localparam logic [NW-1:0] BIT = NW'(1) << (2*(PW-1-j));
      logic [NW-1:0] n_cur, r_cur, trial;

      if (j == 0) begin : g_first
         assign n_cur = {1'b0, radicand};
         assign r_cur = '0;
      end else begin : g_next
         assign n_cur = n_ff[j-1];
         assign r_cur = r_ff[j-1];
      end

      assign trial = r_cur + BIT;

      always_ff @(posedge clock) begin
         if (en) begin
            if (n_cur >= trial) begin
               n_ff[j] <= n_cur - trial;
               r_ff[j] <= (r_cur >> 1) + BIT;
            end else begin
               n_ff[j] <= n_cur;
               r_ff[j] <= r_cur >> 1;
            end
         end
      end
   end

   assign root = r_ff[PW-1][PW-1:0];

endmodule

`default_nettype wire
